>>> sv/adaptive_tap_detector_assert.svh
// ----------------------------------------------------------------------------
// adaptive_tap_detector_assert.svh
// Assertion macros used by the tap detector checker.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TAP_DETECTOR_ASSERT_SVH
`define ADAPTIVE_TAP_DETECTOR_ASSERT_SVH

// Clocked check, masked while reset is high.
`define ADT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ADT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/adt_pkg.sv
// ----------------------------------------------------------------------------
// adt_pkg
// Shared types and constants for the adaptive tap detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adt_pkg;

  localparam int LEVEL_W = 24;
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int MULT_W  = 4;
  localparam int IDX_W   = 8;
  localparam int THR_W   = LEVEL_W + MULT_W;

  // Register indexes on the config channel
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_TAP_LEVEL = 8'd0,
    REG_NOISE_MULT    = 8'd1,
    REG_REFRACTORY    = 8'd2,
    REG_QUIET_REARM   = 8'd3
  } adt_reg_idx_t;

  localparam logic [LEVEL_W-1:0] RST_MIN_TAP_LEVEL = 24'd24000;
  localparam logic [MULT_W-1:0]  RST_NOISE_MULT    = 4'd7;
  localparam logic [DUR_W-1:0]   RST_REFRACTORY    = 16'd150;
  localparam logic [DUR_W-1:0]   RST_QUIET_REARM   = 16'd70;

  typedef enum logic {
    CMD_LEVEL    = 1'b0,
    CMD_SUPPRESS = 1'b1
  } adt_cmd_t;

  typedef struct packed {
    logic               command;
    logic [TIME_W-1:0]  time_ms;
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   suppress_ms;
  } adt_in_t;

  typedef struct packed {
    logic               tap;
    logic [TIME_W-1:0]  tap_time_ms;
    logic [LEVEL_W-1:0] tap_level;
    logic [LEVEL_W-1:0] noise_floor;
  } adt_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [LEVEL_W-1:0] value;
  } adt_cfg_t;

  // Live register set handed to the decision core
  typedef struct packed {
    logic [LEVEL_W-1:0] minimum_tap_level;
    logic [MULT_W-1:0]  noise_multiplier;
    logic [DUR_W-1:0]   refractory_ms;
    logic [DUR_W-1:0]   quiet_to_rearm_ms;
  } adt_regs_t;

endpackage

>>> sv/adt_stream_if.sv
// ----------------------------------------------------------------------------
// adt_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/adaptive_tap_detector.sv
// ----------------------------------------------------------------------------
// adaptive_tap_detector
// Adaptive-threshold tap impulse detector over timestamped peak levels.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink of items {command, time_ms, level, suppress_ms}. A level
//             item may update the noise floor and report a tap; a suppress
//             item moves the suppression deadline to time_ms + suppress_ms.
//   events  : source of exactly one result item per input item
//             {tap, tap_time_ms, tap_level, noise_floor}, in order.
//   cfg     : register writes {index, value}, always ready; index 0..3 as in
//             adt_reg_idx_t, other indexes are dropped. Write only while idle.
// Path: an item accepted into the input register moves on to the result
//   register, with events.valid high, once the result stage is empty or read.
//   Throughput: 1 item per clock while events.ready is high; the detector state is
//   updated in the same cycle the item moves into the result register.
// Reset (rst, synchronous): both stages empty, state cleared (floor 0, not
//   armed, not quiet), registers back to their defaults.
// Stall: while events.ready is low the result holds; one more item still
//   enters the input register, after which samples.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_tap_detector (
  input logic        clk,
  input logic        rst,
  adt_stream_if.sink   samples,
  adt_stream_if.source events,
  adt_stream_if.sink   cfg
);
  import adt_pkg::*;

  // input stage
  logic      in_valid;
  adt_in_t   in_item;
  // result stage
  logic      res_valid;
  adt_out_t  res_item;

  logic      advance;
  adt_out_t  result;
  adt_regs_t regs;

  // item moves from input stage to result stage
  assign advance       = in_valid && (!res_valid || events.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_item <= samples.data;
    end
  end

  adt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (events.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= result;
    end
  end

  assign events.valid = res_valid;
  assign events.data  = res_item;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.minimum_tap_level <= RST_MIN_TAP_LEVEL;
      regs.noise_multiplier  <= RST_NOISE_MULT;
      regs.refractory_ms     <= RST_REFRACTORY;
      regs.quiet_to_rearm_ms <= RST_QUIET_REARM;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_MIN_TAP_LEVEL: regs.minimum_tap_level <= cfg.data.value;
        REG_NOISE_MULT:    regs.noise_multiplier  <= cfg.data.value[MULT_W-1:0];
        REG_REFRACTORY:    regs.refractory_ms     <= cfg.data.value[DUR_W-1:0];
        REG_QUIET_REARM:   regs.quiet_to_rearm_ms <= cfg.data.value[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/adt_core.sv
// ----------------------------------------------------------------------------
// adt_core
// Detector state and combinational decision logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  adt_pkg::adt_in_t   item,
  input  adt_pkg::adt_regs_t regs,
  output adt_pkg::adt_out_t  result
);
  import adt_pkg::*;

  logic [LEVEL_W-1:0] floor_estimate, floor_estimate_next;
  logic               armed, armed_next;
  logic [TIME_W-1:0]  quiet_start, quiet_start_next;
  logic               quiet_valid, quiet_valid_next;
  logic [TIME_W-1:0]  last_tap_time, last_tap_time_next;
  logic [TIME_W-1:0]  suppress_deadline, suppress_deadline_next;

  logic [THR_W-1:0]   scaled, threshold, level_x;
  logic               below, quiet, tap, deadline_ok, refr_ok;
  logic [LEVEL_W+5:0] avg_sum;
  logic [TIME_W-1:0]  qs_eff, quiet_age, since_tap, to_deadline;

  always_comb begin
    scaled    = THR_W'(floor_estimate) * THR_W'(regs.noise_multiplier);
    threshold = (scaled > {{MULT_W{1'b0}}, regs.minimum_tap_level}) ?
                scaled : {{MULT_W{1'b0}}, regs.minimum_tap_level};
    level_x   = {{MULT_W{1'b0}}, item.level};
    below     = level_x < threshold;
    quiet     = level_x < (threshold >> 1);
    // 31*floor + level, then /32
    avg_sum   = ({1'b0, floor_estimate, 5'b0} - {6'b0, floor_estimate})
              + {6'b0, item.level};
    qs_eff      = quiet_valid ? quiet_start : item.time_ms;
    quiet_age   = item.time_ms - qs_eff;
    since_tap   = item.time_ms - last_tap_time;
    to_deadline = item.time_ms - suppress_deadline;
    deadline_ok = !to_deadline[TIME_W-1];
    refr_ok     = since_tap >= {{(TIME_W-DUR_W){1'b0}}, regs.refractory_ms};
    tap = 1'b0;

    floor_estimate_next    = floor_estimate;
    armed_next             = armed;
    quiet_start_next       = quiet_start;
    quiet_valid_next       = quiet_valid;
    last_tap_time_next     = last_tap_time;
    suppress_deadline_next = suppress_deadline;

    if (item.command == CMD_SUPPRESS) begin
      suppress_deadline_next = item.time_ms
                             + {{(TIME_W-DUR_W){1'b0}}, item.suppress_ms};
    end else if (item.level != '0) begin
      if (below) begin
        floor_estimate_next = avg_sum[LEVEL_W+4:5];
      end
      if (quiet) begin
        quiet_valid_next = 1'b1;
        quiet_start_next = qs_eff;
        if (quiet_age >= {{(TIME_W-DUR_W){1'b0}}, regs.quiet_to_rearm_ms}) begin
          armed_next = 1'b1;
        end
      end else begin
        quiet_valid_next = 1'b0;
        quiet_start_next = '0;
      end
      // a quiet item never reaches threshold, so armed is not set and used at once
      if (armed && deadline_ok && refr_ok && !below) begin
        tap                = 1'b1;
        armed_next         = 1'b0;
        last_tap_time_next = item.time_ms;
      end
    end

    result.tap         = tap;
    result.tap_time_ms = tap ? item.time_ms : '0;
    result.tap_level   = tap ? item.level : '0;
    result.noise_floor = floor_estimate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_estimate    <= '0;
      armed             <= 1'b0;
      quiet_start       <= '0;
      quiet_valid       <= 1'b0;
      last_tap_time     <= '0;
      suppress_deadline <= '0;
    end else if (advance) begin
      floor_estimate    <= floor_estimate_next;
      armed             <= armed_next;
      quiet_start       <= quiet_start_next;
      quiet_valid       <= quiet_valid_next;
      last_tap_time     <= last_tap_time_next;
      suppress_deadline <= suppress_deadline_next;
    end
  end

endmodule

>>> sv/adt_checker.sv
// ----------------------------------------------------------------------------
// adt_checker
// Port-level checks for the tap detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_tap_detector_assert.svh"

module adt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           tap,
  input logic [adt_pkg::TIME_W-1:0]     tap_time_ms,
  input logic [adt_pkg::LEVEL_W-1:0]    tap_level
);
  import adt_pkg::*;

  // a result waiting for the receiver stays offered
  `ADT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // reset empties the result stage
  `ADT_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result valid right after reset")

  // no tap reports zero time and level
  `ADT_ASSERT(a_no_tap_zero, out_valid && !tap |-> tap_time_ms == '0 && tap_level == '0, "tap fields set without a tap")

  // a zero level never makes a tap
  `ADT_ASSERT(a_tap_level, out_valid && tap |-> tap_level != '0, "tap with zero level")

endmodule

bind adaptive_tap_detector adt_checker u_adt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (events.valid),
  .out_ready   (events.ready),
  .tap         (events.data.tap),
  .tap_time_ms (events.data.tap_time_ms),
  .tap_level   (events.data.tap_level)
);
